[rtl/spgs_pkg.sv]
// spgs_pkg: shared types and constants for the scrolling palette gradient slew block
// item payload structs, register indexes and the per-channel operand bundle
// no dependencies
`default_nettype none

package spgs_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PALETTE_LOW      = 3'd0;
    localparam logic [2:0] REG_PALETTE_HIGH     = 3'd1;
    localparam logic [2:0] REG_SCROLL_SPEED     = 3'd2;
    localparam logic [2:0] REG_BAND_EXPONENT    = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS_LEVEL = 3'd4;
    localparam logic [2:0] REG_TRANSITION_STEPS = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // arithmetic constants
    localparam logic [3:0]         EXP_MAX          = 4'd11;
    localparam logic [3:0]         SHIFT_BASE       = 4'd4;
    localparam logic signed [15:0] SPEED_DOUBLE_MIN = 16'sd10;
    localparam logic [7:0]         LIMIT_FULL       = 8'd255;
    localparam logic [7:0]         LIMIT_MIN        = 8'd1;
    localparam logic [7:0]         BRIGHTNESS_RESET = 8'd255;

    typedef struct packed {
        logic        advance_frame;
        logic [15:0] led_index;
        logic [7:0]  old_red;
        logic [7:0]  old_green;
        logic [7:0]  old_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] new_red;
        logic [7:0] new_green;
        logic [7:0] new_blue;
    } t_out_item;

    // operands of one channel pass through the shared blend and slew unit
    typedef struct packed {
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [14:0] rem;
        logic [3:0]  shift;
        logic [7:0]  old;
        logic [7:0]  lim;
    } t_chan_op;

endpackage

`default_nettype wire

[rtl/spgs_ifs.sv]
// spgs_ifs: valid/ready channel interfaces for input pixels and result pixels
// depends on spgs_pkg for the payload structs
`default_nettype none

interface spgs_in_if;
    logic                valid;
    logic                ready;
    spgs_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spgs_out_if;
    logic                valid;
    logic                ready;
    spgs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/spgs_chan_unit.sv]
// spgs_chan_unit: shared blend and slew unit, one color channel per use
// blends two expanded palette values across the band, then slew-limits
// depends on spgs_pkg
`default_nettype none

module spgs_chan_unit (
    input  var spgs_pkg::t_chan_op i_op,
    output logic [7:0]             o_value
);

    logic signed [8:0]  w_diff;
    logic signed [24:0] w_diff_ext;
    logic signed [24:0] w_rem_ext;
    logic signed [24:0] w_prod;
    logic signed [24:0] w_scaled;
    logic signed [24:0] w_blend_full;
    logic [7:0]         w_blend;
    logic [8:0]         w_up;
    logic signed [9:0]  w_dn;

    // c1*(w-rem) + c2*rem >> shift  ==  c1 + floor((c2-c1)*rem / w)
    assign w_diff       = $signed({1'b0, i_op.c2}) - $signed({1'b0, i_op.c1});
    assign w_diff_ext   = 25'(w_diff);
    assign w_rem_ext    = $signed({10'b0, i_op.rem});
    assign w_prod       = w_diff_ext * w_rem_ext;
    assign w_scaled     = w_prod >>> i_op.shift;
    assign w_blend_full = $signed({17'b0, i_op.c1}) + w_scaled;
    assign w_blend      = w_blend_full[7:0];

    // slew toward the blended value by at most the step limit
    assign w_up = {1'b0, i_op.old} + {1'b0, i_op.lim};
    assign w_dn = $signed({2'b0, i_op.old}) - $signed({2'b0, i_op.lim});

    always_comb begin
        if (w_blend > i_op.old) begin
            o_value = ({1'b0, w_blend} < w_up) ? w_blend : w_up[7:0];
        end else begin
            o_value = ($signed({2'b0, w_blend}) > w_dn) ? w_blend : w_dn[7:0];
        end
    end

endmodule

`default_nettype wire

[rtl/scrolling_palette_gradient_slew.sv]
// scrolling_palette_gradient_slew: top level, sequencer, divider and registers
// uses spgs_pkg, spgs_in_if, spgs_out_if and spgs_chan_unit
//
// Usage:
//   i_in    pixel channel (valid/ready): advance flag, led index, old rgb.
//   o_out   result channel (valid/ready): new rgb for the same pixel.
//   cfg     write port (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data),
//           always ready; write only while no pixel is in flight.
//   After its input transfer a pixel passes through these steps in
//   order: advance the scroll position, form the band position and fetch
//   both palette entries, run the bit-serial restoring division that gives
//   the step limit, use the shared blend and slew unit (one channel at a
//   time), and load the output register, which then shows the result
//   valid. The next pixel is taken in the idle cycle that follows, so a
//   new pixel is never taken while the sequencer is still busy with one.
//   The output register holds a finished result while the next pixel is
//   taken; if the receiver still stalls when that pixel is done, the
//   sequencer waits in its final state until the output register drains.
//   Synchronous reset clears the scroll position and the registers
//   (brightness level to 255) and empties the output register.
`default_nettype none

module scrolling_palette_gradient_slew (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    spgs_in_if.sink                                 i_in,
    spgs_out_if.source                              o_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [spgs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [spgs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ADV   = 6'b000010,
        ST_POS   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    // configuration registers
    logic [47:0] r_palette_low;
    logic [47:0] r_palette_high;
    logic [15:0] r_scroll_speed;
    logic [3:0]  r_band_exponent;
    logic [7:0]  r_brightness;
    logic [7:0]  r_steps;

    // state and pixel registers
    t_state              r_state, n_state;
    logic [31:0]         r_scroll;
    spgs_pkg::t_in_item  r_item;
    logic [14:0]         r_rem;
    logic [3:0]          r_shift;
    logic [11:0]         r_c1;
    logic [11:0]         r_c2;
    logic [7:0]          r_quot;
    logic [7:0]          r_div_rem;
    logic [2:0]          r_cnt;
    logic [1:0]          r_chan;
    logic [7:0]          r_new_red;
    logic [7:0]          r_new_green;
    logic [7:0]          r_new_blue;
    logic                r_out_valid;
    spgs_pkg::t_out_item r_out_data;

    logic                in_xfer;
    logic                out_xfer;
    logic                out_load;
    logic signed [15:0]  w_speed;
    logic signed [16:0]  w_adv;
    logic [3:0]          w_exp_sat;
    logic [3:0]          w_shift;
    logic [31:0]         w_pos;
    logic [31:0]         w_pos_sh;
    logic [15:0]         w_mask;
    logic [2:0]          w_idx1;
    logic [2:0]          w_idx2;
    logic [8:0]          w_trial;
    logic                w_fits;
    logic [7:0]          w_lim;
    spgs_pkg::t_chan_op  w_op;
    logic [7:0]          w_chan_value;

    function automatic logic [11:0] pal_entry(input logic [2:0] idx,
                                              input logic [47:0] low,
                                              input logic [47:0] high);
        logic [47:0] word;
        word = idx[2] ? high : low;
        case (idx[1:0])
            2'd0:    pal_entry = word[11:0];
            2'd1:    pal_entry = word[23:12];
            2'd2:    pal_entry = word[35:24];
            default: pal_entry = word[47:36];
        endcase
    endfunction

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = r_out_valid && o_out.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_low   <= '0;
            r_palette_high  <= '0;
            r_scroll_speed  <= '0;
            r_band_exponent <= '0;
            r_brightness    <= spgs_pkg::BRIGHTNESS_RESET;
            r_steps         <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spgs_pkg::REG_PALETTE_LOW:      r_palette_low   <= i_cfg_data;
                spgs_pkg::REG_PALETTE_HIGH:     r_palette_high  <= i_cfg_data;
                spgs_pkg::REG_SCROLL_SPEED:     r_scroll_speed  <= i_cfg_data[15:0];
                spgs_pkg::REG_BAND_EXPONENT:    r_band_exponent <= i_cfg_data[3:0];
                spgs_pkg::REG_BRIGHTNESS_LEVEL: r_brightness    <= i_cfg_data[7:0];
                spgs_pkg::REG_TRANSITION_STEPS: r_steps         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // frame advance: doubled speed above the threshold
    assign w_speed = $signed(r_scroll_speed);
    assign w_adv   = (w_speed > spgs_pkg::SPEED_DOUBLE_MIN) ? {w_speed, 1'b0}
                                                            : 17'(w_speed);

    // band position, remainder within the band and palette indexes
    assign w_exp_sat = (r_band_exponent > spgs_pkg::EXP_MAX) ? spgs_pkg::EXP_MAX
                                                             : r_band_exponent;
    assign w_shift   = w_exp_sat + spgs_pkg::SHIFT_BASE;
    assign w_pos     = {16'b0, r_item.led_index} + r_scroll;
    assign w_pos_sh  = w_pos >> w_shift;
    assign w_mask    = (16'h1 << w_shift) - 16'h1;
    assign w_idx1    = w_pos_sh[2:0];
    assign w_idx2    = w_idx1 + 3'd1;

    // one restoring division step per cycle
    assign w_trial = {r_div_rem, r_quot[7]};
    assign w_fits  = (w_trial >= {1'b0, r_steps});

    // step limit from the quotient
    always_comb begin
        if (r_steps == '0) begin
            w_lim = spgs_pkg::LIMIT_FULL;
        end else if (r_quot == '0) begin
            w_lim = spgs_pkg::LIMIT_MIN;
        end else begin
            w_lim = r_quot;
        end
    end

    // operand select for the shared channel unit
    always_comb begin
        w_op.rem   = r_rem;
        w_op.shift = r_shift;
        w_op.lim   = w_lim;
        case (r_chan)
            2'd0: begin
                w_op.c1  = {r_c1[11:8], 4'b0};
                w_op.c2  = {r_c2[11:8], 4'b0};
                w_op.old = r_item.old_red;
            end
            2'd1: begin
                w_op.c1  = {r_c1[7:4], 4'b0};
                w_op.c2  = {r_c2[7:4], 4'b0};
                w_op.old = r_item.old_green;
            end
            default: begin
                w_op.c1  = {r_c1[3:0], 4'b0};
                w_op.c2  = {r_c2[3:0], 4'b0};
                w_op.old = r_item.old_blue;
            end
        endcase
    end

    spgs_chan_unit u_chan (
        .i_op    (w_op),
        .o_value (w_chan_value)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_xfer) n_state = ST_ADV;
            ST_ADV:   n_state = ST_POS;
            ST_POS:   n_state = ST_DIV;
            ST_DIV:   if (r_cnt == 3'd7) n_state = ST_BLEND;
            ST_BLEND: if (r_chan == 2'd2) n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scroll    <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_chan      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ADV && r_item.advance_frame) begin
                r_scroll <= r_scroll + 32'(w_adv);
            end
            if (r_state == ST_POS) begin
                r_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (r_state == ST_DIV) begin
                r_chan <= '0;
            end else if (r_state == ST_BLEND) begin
                r_chan <= r_chan + 2'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in.data;
        end
        if (r_state == ST_POS) begin
            r_rem     <= w_pos[14:0] & w_mask[14:0];
            r_shift   <= w_shift;
            r_c1      <= pal_entry(w_idx1, r_palette_low, r_palette_high);
            r_c2      <= pal_entry(w_idx2, r_palette_low, r_palette_high);
            r_quot    <= r_brightness;
            r_div_rem <= '0;
        end
        if (r_state == ST_DIV) begin
            r_div_rem <= w_fits ? 8'(w_trial - {1'b0, r_steps}) : w_trial[7:0];
            r_quot    <= {r_quot[6:0], w_fits};
        end
        if (r_state == ST_BLEND) begin
            case (r_chan)
                2'd0:    r_new_red   <= w_chan_value;
                2'd1:    r_new_green <= w_chan_value;
                default: r_new_blue  <= w_chan_value;
            endcase
        end
        if (out_load) begin
            r_out_data.new_red   <= r_new_red;
            r_out_data.new_green <= r_new_green;
            r_out_data.new_blue  <= r_new_blue;
        end
    end

endmodule

`default_nettype wire
